### sv/tbd_pkg.sv
package tbd_pkg;

  localparam int CFG_W = 16;

  localparam logic [15:0] EDGE_TIMEOUT_RST = 16'd5000;
  localparam logic [7:0]  SYNC_PULSES_RST  = 8'd16;

  typedef enum logic {
    REG_EDGE_TIMEOUT = 1'b0,
    REG_SYNC_PULSES  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

endpackage

### sv/tbd_edge_if.sv
interface tbd_edge_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_cycles;

  modport source (output valid, func, now_cycles, input ready);
  modport sink (input valid, func, now_cycles, output ready);
endinterface

### sv/tbd_result_if.sv
interface tbd_result_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        receiving;
  logic        lock_lost;
  logic        record_done;
  logic [15:0] record_size;

  modport source (
    output valid, byte_valid, data_byte, byte_index, receiving, lock_lost,
           record_done, record_size,
    input  ready
  );
  modport sink (
    input  valid, byte_valid, data_byte, byte_index, receiving, lock_lost,
           record_done, record_size,
    output ready
  );
endinterface

### sv/tape_biphase_edge_decoder.sv
// channel   | dir | payload                                   | handshake
// ----------+-----+-------------------------------------------+------------
// edges     | in  | func, now_cycles                          | valid/ready
// results   | out | byte_valid, data_byte, byte_index,        | valid/ready
//           |     | receiving, lock_lost, record_done,        |
//           |     | record_size                               |
// cfg       | in  | cfg_we, cfg_index, cfg_data               | write only
//
// one item per cycle sustained while results.ready holds; an accepted item
// passes the input register, then decode logic into the result register.
// the decoder state is updated in the same cycle the result register loads.
// synchronous reset clears the decoder state (sync_left reloads its reset count) and restores register defaults.
// a stalled result holds both stages; edges.ready drops only when both are full.
module tape_biphase_edge_decoder (
  input  logic                      clk,
  input  logic                      rst,
  tbd_edge_if.sink                  edges,
  tbd_result_if.source              results,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [tbd_pkg::CFG_W-1:0] cfg_data
);
  import tbd_pkg::*;

  // configuration
  logic [15:0] edge_timeout;
  logic [7:0]  sync_pulses;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_timeout <= EDGE_TIMEOUT_RST;
      sync_pulses  <= SYNC_PULSES_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_EDGE_TIMEOUT: edge_timeout <= cfg_data;
        REG_SYNC_PULSES:  sync_pulses  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        stage_valid;
  logic        stage_func;
  logic [31:0] stage_now;
  logic        adv;
  logic        fire;

  assign adv         = !results.valid || results.ready;
  assign fire        = stage_valid && adv;
  assign edges.ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (edges.ready) begin
      stage_valid <= edges.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (edges.ready && edges.valid) begin
      stage_func <= edges.func;
      stage_now  <= edges.now_cycles;
    end
  end

  // decoder state
  logic [31:0] last_edge_time, last_edge_time_next;
  logic [15:0] half_period, half_period_next;
  logic [7:0]  sync_left, sync_left_next;
  logic        in_record, in_record_next;
  logic        line_level, line_level_next;
  logic        half_phase, half_phase_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  bits_held, bits_held_next;
  logic [15:0] byte_count, byte_count_next;

  logic        got_byte;
  logic [7:0]  got_value;
  logic [15:0] got_index;
  logic        lost;
  logic        done;

  logic [31:0] t;
  logic [15:0] t16;
  logic [15:0] p_half;
  logic [16:0] p_1p5;
  logic [17:0] p_x3;
  logic [16:0] avg_short;
  logic [16:0] avg_long;
  logic        timed_out;
  logic        too_short;
  logic        is_long;
  logic        do_push;
  logic [7:0]  shifted;
  logic [3:0]  held_inc;

  assign t         = stage_now - last_edge_time;
  assign t16       = t[15:0];
  assign p_half    = {1'b0, half_period[15:1]};
  assign p_1p5     = {1'b0, half_period} + {2'b0, half_period[15:1]};
  assign p_x3      = {2'b0, half_period} + {1'b0, half_period, 1'b0};
  // t fits 16 bits whenever these averages are used (t <= edge_timeout)
  assign avg_short = {1'b0, half_period} + {1'b0, t16};
  assign avg_long  = {1'b0, half_period} + {2'b0, t16[15:1]};
  assign timed_out = t > {16'b0, edge_timeout};
  assign too_short = t < {16'b0, p_half};
  assign is_long   = t >= {15'b0, p_1p5};

  always_comb begin
    last_edge_time_next = last_edge_time;
    half_period_next    = half_period;
    sync_left_next      = sync_left;
    in_record_next      = in_record;
    line_level_next     = line_level;
    half_phase_next     = half_phase;
    shift_byte_next     = shift_byte;
    bits_held_next      = bits_held;
    byte_count_next     = byte_count;
    got_byte            = 1'b0;
    got_value           = 8'd0;
    got_index           = 16'd0;
    lost                = 1'b0;
    done                = 1'b0;
    do_push             = 1'b0;

    if (func_t'(stage_func) == FUNC_POLL) begin
      if (in_record && timed_out) begin
        in_record_next = 1'b0;
        done           = 1'b1;
      end
    end else begin
      last_edge_time_next = stage_now;
      if (timed_out) begin
        sync_left_next = sync_pulses;
        in_record_next = 1'b0;
        lost           = 1'b1;
      end else if (sync_left != 8'd0) begin
        // still averaging the sync run
        if (too_short || t > {15'b0, p_1p5}) begin
          half_period_next = t16;
          sync_left_next   = sync_pulses;
          in_record_next   = 1'b0;
          lost             = 1'b1;
        end else begin
          half_period_next = avg_short[16:1];
          sync_left_next   = sync_left - 8'd1;
        end
      end else if (too_short || t > {14'b0, p_x3}) begin
        half_period_next = t16;
        sync_left_next   = sync_pulses;
        in_record_next   = 1'b0;
        lost             = 1'b1;
      end else begin
        half_period_next = is_long ? avg_long[16:1] : avg_short[16:1];
        if (!in_record) begin
          if (is_long) begin
            // record start: first bit is a one
            line_level_next = 1'b1;
            half_phase_next = 1'b1;
            shift_byte_next = 8'd1;
            bits_held_next  = 4'd1;
            byte_count_next = 16'd0;
            in_record_next  = 1'b1;
          end
        end else if (is_long) begin
          line_level_next = ~line_level;
          half_phase_next = 1'b1;
          do_push         = 1'b1;
        end else begin
          half_phase_next = ~half_phase;
          do_push         = ~half_phase;
        end
      end
    end

    shifted  = {shift_byte[6:0], line_level_next};
    held_inc = bits_held + 4'd1;
    if (do_push) begin
      if (held_inc[3]) begin
        got_byte        = 1'b1;
        got_value       = shifted;
        got_index       = byte_count;
        byte_count_next = byte_count + 16'd1;
        shift_byte_next = 8'd0;
        bits_held_next  = 4'd0;
      end else begin
        shift_byte_next = shifted;
        bits_held_next  = held_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= 32'd0;
      half_period    <= 16'd0;
      sync_left      <= SYNC_PULSES_RST;
      in_record      <= 1'b0;
      line_level     <= 1'b0;
      half_phase     <= 1'b0;
      shift_byte     <= 8'd0;
      bits_held      <= 4'd0;
      byte_count     <= 16'd0;
    end else if (fire) begin
      last_edge_time <= last_edge_time_next;
      half_period    <= half_period_next;
      sync_left      <= sync_left_next;
      in_record      <= in_record_next;
      line_level     <= line_level_next;
      half_phase     <= half_phase_next;
      shift_byte     <= shift_byte_next;
      bits_held      <= bits_held_next;
      byte_count     <= byte_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv) begin
      results.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.byte_valid  <= got_byte;
      results.data_byte   <= got_value;
      results.byte_index  <= got_index;
      results.receiving   <= in_record_next;
      results.lock_lost   <= lost;
      results.record_done <= done;
      results.record_size <= byte_count_next;
    end
  end

  // checks
  a_bits_below_byte: assert property (@(posedge clk) disable iff (rst)
    bits_held[3] == 1'b0)
    else $error("bit count reached a full byte without emitting");

  a_byte_in_record: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.byte_valid |-> results.receiving)
    else $error("byte emitted outside a record");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.record_done |-> !results.receiving && !results.byte_valid)
    else $error("record end reported with record still open");

  a_lost_closes: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.lock_lost |-> !results.receiving && !results.byte_valid)
    else $error("lock loss reported with record still open");

endmodule

### dv/tape_biphase_edge_decoder_tb.sv
module tape_biphase_edge_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbd_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [31:0] now;
  } edge_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        receiving;
    logic        lock_lost;
    logic        record_done;
    logic [15:0] record_size;
  } decode_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  tbd_edge_if   edges_ch ();
  tbd_result_if results_ch ();

  tape_biphase_edge_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .edges     (edges_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  edge_item_t     edge_items[$];
  decode_result_t expected_results[$];

  // decoder copy: registers and state
  logic [15:0] gap_limit;
  logic [7:0]  lock_need;
  logic [31:0] prev_stamp;
  logic [15:0] period_est;
  logic [7:0]  sync_to_go;
  logic        rec_open;
  logic        level_now;
  logic        phase_now;
  logic [7:0]  byte_acc;
  logic [3:0]  acc_bits;
  logic [15:0] rec_bytes;

  logic [31:0]    stamp;
  edge_item_t     next_item;
  edge_item_t     seen_item;
  decode_result_t pred_res;
  decode_result_t want;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        held_off = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned take_gap = 0;
  int unsigned take_calm = 0;
  int unsigned hold_left = 0;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_seen = 0;
  int unsigned resyncs_seen = 0;
  int unsigned ends_seen = 0;

  task automatic drop_lock(inout decode_result_t r);
    sync_to_go = lock_need;
    rec_open = 1'b0;
    r.lock_lost = 1'b1;
  endtask

  task automatic shift_in_level(inout decode_result_t r);
    byte_acc = {byte_acc[6:0], level_now};
    acc_bits = acc_bits + 4'd1;
    if (acc_bits >= 4'd8) begin
      r.byte_valid = 1'b1;
      r.data_byte = byte_acc;
      r.byte_index = rec_bytes;
      rec_bytes = rec_bytes + 16'd1;
      byte_acc = '0;
      acc_bits = '0;
    end
  endtask

  task automatic decode_item(input edge_item_t it, output decode_result_t r);
    logic [31:0] dt;
    logic [31:0] p;
    logic [31:0] avg;
    logic        is_long;
    r = '0;
    dt = it.now - prev_stamp;
    p = {16'd0, period_est};
    if (it.func == FUNC_POLL) begin
      if (rec_open && dt > {16'd0, gap_limit}) begin
        rec_open = 1'b0;
        r.record_done = 1'b1;
      end
    end else begin
      prev_stamp = it.now;
      if (dt > {16'd0, gap_limit}) begin
        drop_lock(r);
      end else if (sync_to_go != 8'd0) begin
        if (dt < p / 2 || dt > p + p / 2) begin
          period_est = dt[15:0];
          drop_lock(r);
        end else begin
          avg = (p + dt) / 2;
          period_est = avg[15:0];
          sync_to_go = sync_to_go - 8'd1;
        end
      end else if (dt < p / 2 || dt > p * 3) begin
        period_est = dt[15:0];
        drop_lock(r);
      end else begin
        is_long = (dt >= p + p / 2);
        // long intervals count as two half periods when tracking
        avg = is_long ? (p + dt / 2) / 2 : (p + dt) / 2;
        period_est = avg[15:0];
        if (!rec_open) begin
          if (is_long) begin
            level_now = 1'b1;
            phase_now = 1'b1;
            byte_acc = 8'd1;
            acc_bits = 4'd1;
            rec_bytes = 16'd0;
            rec_open = 1'b1;
          end
        end else if (is_long) begin
          level_now = ~level_now;
          phase_now = 1'b1;
          shift_in_level(r);
        end else begin
          // second short of a pair repeats the level
          phase_now = ~phase_now;
          if (phase_now) shift_in_level(r);
        end
      end
    end
    r.receiving = rec_open;
    r.record_size = rec_bytes;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
    end
  endtask

  task automatic pick_gap(inout int unsigned calm, output int unsigned len);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      len = 0;
    end else if (roll < 3) begin
      calm = $urandom_range(20, 80);
      len = 0;
    end else if (roll < 60) begin
      len = 0;
    end else if (roll < 90) begin
      len = $urandom_range(1, 3);
    end else if (roll < 98) begin
      len = $urandom_range(4, 12);
    end else begin
      len = $urandom_range(20, 50);
    end
  endtask

  // result check first, then the newly accepted item
  always @(posedge clk) begin
    out_fire = !rst && results_ch.valid && results_ch.ready;
    in_fire = !rst && edges_ch.valid && edges_ch.ready;
    if (out_fire) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("result item arrived with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("byte_valid", 32'(want.byte_valid), 32'(results_ch.byte_valid));
        check_field("data_byte", 32'(want.data_byte), 32'(results_ch.data_byte));
        check_field("byte_index", 32'(want.byte_index), 32'(results_ch.byte_index));
        check_field("receiving", 32'(want.receiving), 32'(results_ch.receiving));
        check_field("lock_lost", 32'(want.lock_lost), 32'(results_ch.lock_lost));
        check_field("record_done", 32'(want.record_done),
                    32'(results_ch.record_done));
        check_field("record_size", 32'(want.record_size),
                    32'(results_ch.record_size));
        if (want.byte_valid) bytes_seen++;
        if (want.lock_lost) resyncs_seen++;
        if (want.record_done) ends_seen++;
      end
    end
    if (in_fire) begin
      seen_item.func = func_t'(edges_ch.func);
      seen_item.now = edges_ch.now_cycles;
      decode_item(seen_item, pred_res);
      expected_results.push_back(pred_res);
      items_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      edges_ch.valid <= 1'b0;
    end else if (!edges_ch.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        edges_ch.valid <= 1'b0;
      end else if (edge_items.size() > 0) begin
        next_item = edge_items.pop_front();
        edges_ch.valid <= 1'b1;
        edges_ch.func <= next_item.func;
        edges_ch.now_cycles <= next_item.now;
        pick_gap(send_calm, send_gap);
      end else begin
        edges_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (out_fire) pick_gap(take_calm, take_gap);
      // one long hold-off so the pipeline fills and back-pressures the sender
      if (!held_off && results_seen >= 300) begin
        held_off = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input func_t f, input logic [31:0] at);
    edge_item_t it;
    it.func = f;
    it.now = at;
    edge_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_edge(input int unsigned dt);
    stamp = stamp + dt;
    queue_item(FUNC_EDGE, stamp);
  endtask

  task automatic queue_poll(input int unsigned dt);
    queue_item(FUNC_POLL, stamp + dt);
  endtask

  function automatic int unsigned wobble(input int unsigned h);
    int unsigned j;
    j = h / 8;
    return h - j + $urandom_range(0, 2 * j);
  endfunction

  // timeout gap, sync preamble, opening long (first bit), nbits-1 more biphase bits, optional end
  task automatic queue_record(input int unsigned h, input int unsigned nbits);
    int unsigned preamble;
    logic        lvl;
    logic        b;
    preamble = lock_need + 2;
    if (preamble < 6) preamble = 6;
    queue_edge(gap_limit + $urandom_range(1, 200));
    repeat (preamble) queue_edge(wobble(h));
    queue_edge(wobble(2 * h));
    lvl = 1'b1;
    for (int i = 1; i < nbits; i++) begin
      b = 1'($urandom_range(0, 1));
      if (b != lvl) begin
        queue_edge(wobble(2 * h));
        lvl = b;
      end else begin
        queue_edge(wobble(h));
        queue_edge(wobble(h));
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        queue_poll($urandom_range(0, gap_limit));
        queue_poll(gap_limit + $urandom_range(1, 100));
      end
      1: queue_edge($urandom_range(0, h / 3));
      2: queue_edge($urandom_range(3 * h + 1, 5 * h));
      default: ;
    endcase
  endtask

  task automatic queue_random(input int unsigned upto);
    int unsigned h;
    int unsigned hcap;
    int unsigned pick;
    while (items_queued < upto) begin
      hcap = gap_limit / 3;
      if (hcap > 600) hcap = 600;
      if (hcap < 8) hcap = 8;
      if ($urandom_range(0, 4) != 0 && hcap > 60) h = $urandom_range(8, 60);
      else h = $urandom_range(8, hcap);
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        queue_record(h, 8 * $urandom_range(1, 6));
      end else if (pick < 15) begin
        queue_record(h, $urandom_range(1, 40));
      end else if (pick < 18) begin
        repeat ($urandom_range(5, 20)) begin
          if ($urandom_range(0, 4) != 0) queue_edge($urandom_range(0, 4 * h));
          else queue_poll($urandom_range(0, 2 * gap_limit + 2));
        end
      end else begin
        stamp = $urandom();
        queue_item(FUNC_EDGE, stamp);
        queue_item(FUNC_POLL, $urandom());
      end
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_EDGE_TIMEOUT) gap_limit = val;
    else lock_need = val[7:0];
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    edges_ch.valid = 1'b0;
    edges_ch.func = FUNC_EDGE;
    edges_ch.now_cycles = '0;
    results_ch.ready = 1'b0;
    gap_limit = EDGE_TIMEOUT_RST;
    lock_need = SYNC_PULSES_RST;
    prev_stamp = '0;
    period_est = '0;
    sync_to_go = SYNC_PULSES_RST;
    rec_open = 1'b0;
    level_now = 1'b0;
    phase_now = 1'b0;
    byte_acc = '0;
    acc_bits = '0;
    rec_bytes = '0;
    stamp = 32'hFFFF_FFE0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    @(posedge clk);

    write_reg(REG_EDGE_TIMEOUT, 16'hFFFF);
    write_reg(REG_SYNC_PULSES, 16'd1);
    queue_edge(0);        // huge interval since reset: timeout with nothing locked
    queue_poll(10);       // poll while idle
    queue_edge(20);       // no period yet, so a bad interval
    queue_edge(20);       // locks, counter wraps here
    queue_edge(20);       // locked short before any record
    queue_edge(40);       // record opens, first bit one
    queue_edge(40);
    queue_edge(20);
    queue_edge(20);
    queue_edge(40);
    queue_edge(20);
    queue_edge(20);
    queue_edge(40);
    queue_edge(40);
    queue_edge(40);       // completes the first byte
    queue_poll(100);      // poll before the timeout
    queue_poll(65536);    // poll just past the largest timeout
    queue_edge(9);        // too short
    queue_edge(9);
    queue_edge(28);       // too long once locked
    queue_edge(65536);    // edge timeout
    queue_edge(0);
    wait_drained();

    // zero timeout and zero sync count
    write_reg(REG_EDGE_TIMEOUT, 16'd0);
    write_reg(REG_SYNC_PULSES, 16'd0);
    queue_edge(0);
    queue_edge(1);
    queue_edge(0);
    queue_poll(0);
    queue_poll(1);
    wait_drained();

    write_reg(REG_EDGE_TIMEOUT, EDGE_TIMEOUT_RST);
    write_reg(REG_SYNC_PULSES, 16'(SYNC_PULSES_RST));
    queue_random(items_queued + 400);
    wait_drained();

    write_reg(REG_EDGE_TIMEOUT, 16'hFFFF);
    write_reg(REG_SYNC_PULSES, 16'd1);
    queue_random(items_queued + 350);
    wait_drained();

    write_reg(REG_EDGE_TIMEOUT, 16'($urandom_range(2000, 9000)));
    write_reg(REG_SYNC_PULSES, 16'd255);
    queue_random(items_queued + 350);
    wait_drained();

    write_reg(REG_EDGE_TIMEOUT, 16'd1);
    write_reg(REG_SYNC_PULSES, 16'($urandom_range(2, 30)));
    queue_random(items_queued + 100);
    wait_drained();

    write_reg(REG_EDGE_TIMEOUT, 16'($urandom_range(500, 3000)));
    write_reg(REG_SYNC_PULSES, 16'd0);
    queue_random(items_queued + 300);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("decoded %0d items: %0d bytes, %0d resyncs, %0d records ended by poll",
             results_seen, bytes_seen, resyncs_seen, ends_seen);
    $display("timeouts from zero to full scale, sync runs from zero to 255, one long stall");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
